/* hdl/cea608_caption_pair_encoder_macros.svh */
// Assertion macros shared by the caption pair encoder modules.
`ifndef CEA608_CAPTION_PAIR_ENCODER_MACROS_SVH
`define CEA608_CAPTION_PAIR_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define CPE_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define CPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cea608cpe_pkg.sv */
// Types, codes and constant caption pairs for the caption pair encoder.
package cea608cpe_pkg;

	typedef struct packed {
		logic [6:0] first;
		logic [6:0] second;
	} pair_t;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_CHAR  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [2:0] MARK_FIELD1 = 3'd4;
	localparam logic [2:0] MARK_FIELD2 = 3'd5;

	localparam logic [6:0] SPACE_CHAR = 7'h20;
	localparam logic [6:0] NULL_CHAR  = 7'h00;

	// Index of the first preamble pair and of the carriage-return pair.
	localparam logic [1:0] LOAD_FIRST_IDX = 2'd0;
	localparam logic [1:0] LOAD_CR_IDX    = 2'd3;

	// Roll-up preamble (RCL, RU2, PAC 11h 5Ch) followed by carriage return.
	function automatic pair_t preamble_pair(input logic [1:0] idx);
		pair_t p;
		case (idx)
			2'd0: p = '{first: 7'h14, second: 7'h20};
			2'd1: p = '{first: 7'h14, second: 7'h25};
			2'd2: p = '{first: 7'h11, second: 7'h5C};
			default: p = '{first: 7'h14, second: 7'h2D};
		endcase
		return p;
	endfunction

	// Drop bit 7 and turn control codes into a space.
	function automatic logic [6:0] clean_char(input logic [7:0] v);
		logic [6:0] x;
		x = v[6:0];
		return (x[6:5] == 2'b00) ? SPACE_CHAR : x;
	endfunction

	// Put odd parity in bit 7.
	function automatic logic [7:0] with_parity(input logic [6:0] v);
		return {~^v, v};
	endfunction

endpackage

/* hdl/cea608cpe_ifs.sv */
// Valid/ready channel interfaces for command requests and cc_data triplets.
interface cea608cpe_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] character;

	modport source(output valid, output command, output character, input ready);
	modport sink(input valid, input command, input character, output ready);
endinterface

interface cea608cpe_trip_if;
	logic       valid;
	logic       ready;
	logic [2:0] field_marker;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic       last_of_frame;

	modport source(output valid, output field_marker, output first_byte,
		output second_byte, output last_of_frame, input ready);
	modport sink(input valid, input field_marker, input first_byte,
		input second_byte, input last_of_frame, output ready);
endinterface

/* hdl/cea608_caption_pair_encoder.sv */
// Top level of the roll-up caption pair encoder.
// A start request is accepted and its pairs are then written into the pair
// memory in a load state: the four preamble pairs after the first start since
// reset, only the carriage-return pair after later ones. A character request is
// written in the cycle it is accepted. A frame tick yields 2 * PAIRS_PER_TICK
// triplets, one per cycle while the output is taken, set by the back end's
// two-step emit loop on the pair memory's single registered read port. Up to
// two ticks are queued ahead of the back end; a start or character request is
// held off until all queued ticks have been emitted, since it rewrites the
// memory, which holds 4 + (MAX_CHARS + 1) / 2 entries and is never cleared.
module cea608_caption_pair_encoder #(
	parameter int MAX_CHARS      = 32,
	parameter int PAIRS_PER_TICK = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	cea608cpe_cmd_if.sink     cmd,
	cea608cpe_trip_if.source  triplet
);

	localparam int STORE_DEPTH = 4 + (MAX_CHARS + 1) / 2;
	localparam int CW          = $clog2(STORE_DEPTH + 1);
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CHW         = $clog2(MAX_CHARS + 1);
	localparam int PW          = (PAIRS_PER_TICK > 1) ? $clog2(PAIRS_PER_TICK) : 1;

	logic          push;
	logic [CW:0]   push_data;
	logic          pop;
	logic [CW:0]   pop_data;
	logic          q_full;
	logic          q_empty;
	logic          back_idle;
	logic [AW-1:0] rd_addr;
	cea608cpe_pkg::pair_t rd_pair;

	cea608cpe_front #(
		.MAX_CHARS  (MAX_CHARS),
		.STORE_DEPTH(STORE_DEPTH),
		.CW         (CW),
		.AW         (AW),
		.CHW        (CHW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_full   (q_full),
		.q_empty  (q_empty),
		.back_idle(back_idle),
		.push     (push),
		.push_data(push_data),
		.rd_addr  (rd_addr),
		.rd_pair_q(rd_pair)
	);

	cea608cpe_queue #(
		.W(CW + 1)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	cea608cpe_back #(
		.PAIRS_PER_TICK(PAIRS_PER_TICK),
		.CW            (CW),
		.AW            (AW),
		.PW            (PW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_data (pop_data),
		.pop    (pop),
		.rd_addr(rd_addr),
		.rd_pair(rd_pair),
		.idle   (back_idle),
		.triplet(triplet)
	);

endmodule

/* hdl/cea608cpe_queue.sv */
// Two-entry queue of work for the back end (start marks and frame ticks).
`include "cea608_caption_pair_encoder_macros.svh"

module cea608cpe_queue #(
	parameter int W = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] data_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	`CPE_ASSERT_IMPLY(a_no_push_when_full, push, !full, "queue pushed while full")
	`CPE_ASSERT_IMPLY(a_no_pop_when_empty, pop, !empty, "queue popped while empty")

endmodule

/* hdl/cea608cpe_front.sv */
// Front end: takes requests, cleans characters and fills the pair memory.
`include "cea608_caption_pair_encoder_macros.svh"

module cea608cpe_front #(
	parameter int MAX_CHARS   = 32,
	parameter int STORE_DEPTH = 20,
	parameter int CW          = 5,
	parameter int AW          = 5,
	parameter int CHW         = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cea608cpe_cmd_if.sink         cmd,
	input  logic                  q_full,
	input  logic                  q_empty,
	input  logic                  back_idle,
	output logic                  push,
	output logic [CW:0]           push_data,
	input  logic [AW-1:0]         rd_addr,
	output cea608cpe_pkg::pair_t  rd_pair_q
);

	localparam logic FR_IDLE = 1'b0;
	localparam logic FR_LOAD = 1'b1;

	logic           state_q;
	logic [CW-1:0]  pc_q;
	logic [CHW-1:0] chars_q;
	logic           preamble_q;
	logic [1:0]     load_idx_q;

	logic [6:0] first_mem  [STORE_DEPTH];
	logic [6:0] second_mem [STORE_DEPTH];

	logic          accept;
	logic          drained;
	logic          room;
	logic          chars_left;
	logic          we_first;
	logic          we_second;
	logic [AW-1:0] wr_addr;
	logic [6:0]    wr_first;
	logic [6:0]    wr_second;
	logic [6:0]    clean;
	logic [CW-1:0] pc_prev;
	cea608cpe_pkg::pair_t load_pair;

	assign drained    = q_empty && back_idle;
	assign room       = (pc_q < CW'(STORE_DEPTH));
	assign chars_left = (chars_q < CHW'(MAX_CHARS));
	assign clean      = cea608cpe_pkg::clean_char(cmd.character);
	assign pc_prev    = pc_q - CW'(1);
	assign load_pair  = cea608cpe_pkg::preamble_pair(load_idx_q);
	assign accept     = cmd.valid && cmd.ready;

	// Starts and characters touch the pair memory, so they wait until every
	// queued tick has been read out by the back end.
	always_comb begin
		cmd.ready = 1'b0;
		if (state_q == FR_IDLE) begin
			case (cmd.command)
				cea608cpe_pkg::CMD_START: cmd.ready = drained;
				cea608cpe_pkg::CMD_CHAR:  cmd.ready = drained;
				cea608cpe_pkg::CMD_TICK:  cmd.ready = !q_full;
				default:                  cmd.ready = 1'b1;
			endcase
		end
	end

	assign push = accept && (cmd.command == cea608cpe_pkg::CMD_START ||
		cmd.command == cea608cpe_pkg::CMD_TICK);
	assign push_data = {cmd.command == cea608cpe_pkg::CMD_START, pc_q};

	always_comb begin
		we_first  = 1'b0;
		we_second = 1'b0;
		wr_addr   = pc_q[AW-1:0];
		wr_first  = load_pair.first;
		wr_second = load_pair.second;
		if (state_q == FR_LOAD) begin
			we_first  = room;
			we_second = room;
		end else if (accept && cmd.command == cea608cpe_pkg::CMD_CHAR && chars_left) begin
			wr_first  = clean;
			if (!chars_q[0]) begin
				we_first  = room;
				we_second = room;
				wr_second = cea608cpe_pkg::SPACE_CHAR;
			end else begin
				we_second = (pc_q != '0);
				wr_addr   = pc_prev[AW-1:0];
				wr_second = clean;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FR_IDLE;
			pc_q       <= '0;
			chars_q    <= '0;
			preamble_q <= 1'b0;
			load_idx_q <= cea608cpe_pkg::LOAD_FIRST_IDX;
		end else if (state_q == FR_LOAD) begin
			if (room) begin
				pc_q <= pc_q + CW'(1);
			end
			if (load_idx_q == cea608cpe_pkg::LOAD_CR_IDX) begin
				state_q <= FR_IDLE;
			end else begin
				load_idx_q <= load_idx_q + 2'd1;
			end
		end else if (accept) begin
			case (cmd.command)
				cea608cpe_pkg::CMD_START: begin
					pc_q       <= '0;
					chars_q    <= '0;
					preamble_q <= 1'b1;
					load_idx_q <= preamble_q ? cea608cpe_pkg::LOAD_CR_IDX
						: cea608cpe_pkg::LOAD_FIRST_IDX;
					state_q    <= FR_LOAD;
				end
				cea608cpe_pkg::CMD_CHAR: begin
					if (chars_left) begin
						chars_q <= chars_q + CHW'(1);
						if (!chars_q[0] && room) begin
							pc_q <= pc_q + CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we_first) begin
			first_mem[wr_addr] <= wr_first;
		end
		if (we_second) begin
			second_mem[wr_addr] <= wr_second;
		end
		rd_pair_q.first  <= first_mem[rd_addr];
		rd_pair_q.second <= second_mem[rd_addr];
	end

	`CPE_ASSERT_IMPLY(a_write_only_when_drained, accept && (cmd.command == cea608cpe_pkg::CMD_START || cmd.command == cea608cpe_pkg::CMD_CHAR), drained, "memory update while ticks pending")
	`CPE_ASSERT_NEXT(a_load_ends_idle, state_q == FR_LOAD && load_idx_q == cea608cpe_pkg::LOAD_CR_IDX, state_q == FR_IDLE, "pair load did not finish")

endmodule

/* hdl/cea608cpe_back.sv */
// Back end: reads queued pairs and emits two parity-coded triplets per pair.
`include "cea608_caption_pair_encoder_macros.svh"

module cea608cpe_back #(
	parameter int PAIRS_PER_TICK = 3,
	parameter int CW             = 5,
	parameter int AW             = 5,
	parameter int PW             = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  logic [CW:0]           q_data,
	output logic                  pop,
	output logic [AW-1:0]         rd_addr,
	input  cea608cpe_pkg::pair_t  rd_pair,
	output logic                  idle,
	cea608cpe_trip_if.source      triplet
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_F1   = 2'd1;
	localparam logic [1:0] B_F2   = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] sp_q;
	logic [CW-1:0] pc_q;
	logic          sending_q;
	logic [PW-1:0] pi_q;
	logic          valid_q;
	logic [2:0]    marker_q;
	logic [7:0]    first_q;
	logic [7:0]    second_q;
	logic          last_q;

	logic          slot_free;
	logic          emit;
	logic          hit;
	logic          last_pair;
	logic [CW-1:0] sp_next;
	logic [6:0]    byte_a;
	logic [6:0]    byte_b;

	assign slot_free = !valid_q || triplet.ready;
	assign emit      = (state_q == B_F1 || state_q == B_F2) && slot_free;
	assign pop       = (state_q == B_IDLE) && !q_empty;
	assign idle      = (state_q == B_IDLE);
	assign rd_addr   = sp_q[AW-1:0];
	assign hit       = sending_q && (sp_q < pc_q);
	assign sp_next   = sp_q + CW'(1);
	assign last_pair = (pi_q == PW'(PAIRS_PER_TICK - 1));
	// Once the stored pairs are used up, null pairs go out; the null byte with parity is 0x80.
	assign byte_a    = hit ? rd_pair.first  : cea608cpe_pkg::NULL_CHAR;
	assign byte_b    = hit ? rd_pair.second : cea608cpe_pkg::NULL_CHAR;

	assign triplet.valid         = valid_q;
	assign triplet.field_marker  = marker_q;
	assign triplet.first_byte    = first_q;
	assign triplet.second_byte   = second_q;
	assign triplet.last_of_frame = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			sp_q      <= '0;
			pc_q      <= '0;
			sending_q <= 1'b0;
			pi_q      <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (triplet.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (q_data[CW]) begin
							sp_q      <= '0;
							sending_q <= 1'b1;
						end else begin
							pc_q    <= q_data[CW-1:0];
							pi_q    <= '0;
							state_q <= B_F1;
						end
					end
				end
				B_F1: begin
					if (slot_free) begin
						state_q <= B_F2;
						if (hit) begin
							sp_q <= sp_next;
							if (sp_next >= pc_q) begin
								sending_q <= 1'b0;
							end
						end else begin
							sending_q <= 1'b0;
						end
					end
				end
				B_F2: begin
					if (slot_free) begin
						if (last_pair) begin
							state_q <= B_IDLE;
						end else begin
							pi_q    <= pi_q + PW'(1);
							state_q <= B_F1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// The field-2 triplet repeats the bytes latched for field 1.
	always_ff @(posedge clk) begin
		if (state_q == B_F1 && slot_free) begin
			marker_q <= cea608cpe_pkg::MARK_FIELD1;
			first_q  <= cea608cpe_pkg::with_parity(byte_a);
			second_q <= cea608cpe_pkg::with_parity(byte_b);
			last_q   <= 1'b0;
		end else if (state_q == B_F2 && slot_free) begin
			marker_q <= cea608cpe_pkg::MARK_FIELD2;
			last_q   <= last_pair;
		end
	end

	`CPE_ASSERT_IMPLY(a_field2_pending, state_q == B_F2, valid_q, "field-2 step without field-1 triplet")
	`CPE_ASSERT_IMPLY(a_last_is_field2, valid_q && last_q, marker_q == cea608cpe_pkg::MARK_FIELD2, "frame end on a field-1 triplet")

endmodule
